### rtl/point_in_polygon_with_holes_core_macros.svh
// Assertion macros for the point-in-polygon core.
// Expect clk and arst_n in the scope of the module that uses them.
`ifndef POINT_IN_POLYGON_WITH_HOLES_CORE_MACROS_SVH
`define POINT_IN_POLYGON_WITH_HOLES_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define PIP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PIP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/pip_holes_pkg.sv
// Package for the point-in-polygon core: command codes, sequencer states, defaults.
// No dependencies.
package pip_holes_pkg;

	localparam int MAX_VERTICES_DEF = 64;
	localparam int COORD_WIDTH_DEF  = 32;
	localparam int RING_MIN         = 3;   // smallest ring that can enclose a point
	localparam int RING_CNT_W       = $clog2(RING_MIN + 1);

	localparam logic [1:0] MODE_CLEAR = 2'd0;
	localparam logic [1:0] MODE_LOAD  = 2'd1;
	localparam logic [1:0] MODE_QUERY = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN
	} state_t;

endpackage

### rtl/point_in_polygon_with_holes_core.sv
// Point-in-polygon core with holes: vertex store, edge walker and crossing test.
// Depends on pip_holes_pkg and point_in_polygon_with_holes_core_macros.svh.
//
//  channel   strobe          payload                                 flow control
//  command   start & !busy   mode, coord_x, coord_y, new_ring        busy holds off
//  result    done            inside_res, overflowed                  none, one cycle
//
// Clear and load give no result; busy stays low.
// A query walks the vertex store through its single read port, one vertex a
// cycle, then one extra beat closes the last ring; done is registered from the
// flush beat once it has passed stages s1, s2 and s3.
// Reset is asynchronous and empties the store; vertex entries are never cleared.
// busy is high for the whole query and drops in the cycle done is shown.
`include "point_in_polygon_with_holes_core_macros.svh"

module point_in_polygon_with_holes_core #(
	parameter int MAX_VERTICES = pip_holes_pkg::MAX_VERTICES_DEF,
	parameter int COORD_WIDTH  = pip_holes_pkg::COORD_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [31:0] coord_x,
	input  logic [31:0] coord_y,
	input  logic        new_ring,
	output logic        done,
	output logic        inside_res,
	output logic        overflowed
);
	import pip_holes_pkg::*;

	localparam int CW   = COORD_WIDTH;
	localparam int DW   = CW + 1;            // coordinate differences
	localparam int PW   = 2 * DW;            // exact cross products
	localparam int EW   = 2 * CW + 1;        // store entry: {ring begin, y, x}
	localparam int IW   = $clog2(MAX_VERTICES);
	localparam int CNTW = $clog2(MAX_VERTICES + 1);
	localparam logic [CNTW-1:0] CNT_MAX = CNTW'(MAX_VERTICES);

	// ------------------------------------------------------------------
	// Vertex store: one write port (loads), one registered read port (walk)
	// ------------------------------------------------------------------
	logic [EW-1:0] vtx_mem [MAX_VERTICES];

	logic [CNTW-1:0] cnt_q;      // vertices held
	logic            ovf_q;      // sticky dropped-load flag
	logic [CNTW-1:0] rd_idx_q;   // walk pointer
	logic signed [CW-1:0] px_q, py_q;

	state_t state_q, state_d;

	logic accept;
	logic is_query, is_load, is_clear;
	logic wr_en;
	logic iss_rd, iss_flush;

	assign accept   = start && !busy;
	assign is_clear = accept && (mode == MODE_CLEAR);
	assign is_load  = accept && (mode == MODE_LOAD);
	assign is_query = accept && (mode == MODE_QUERY);
	assign wr_en    = is_load && (cnt_q != CNT_MAX);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	logic flush_s3;

	always_comb begin
		state_d   = state_q;
		busy      = 1'b1;
		iss_rd    = 1'b0;
		iss_flush = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (is_query) state_d = ST_WALK;
			end
			ST_WALK: begin
				if (rd_idx_q == cnt_q) begin
					iss_flush = 1'b1;   // closes the last open ring
					state_d   = ST_DRAIN;
				end else begin
					iss_rd = 1'b1;
				end
			end
			ST_DRAIN: begin
				if (flush_s3) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Count, overflow, walk pointer, query point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			ovf_q    <= 1'b0;
			rd_idx_q <= '0;
		end else begin
			if (is_clear) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else if (is_load) begin
				if (cnt_q == CNT_MAX) ovf_q <= 1'b1;
				else                  cnt_q <= cnt_q + 1'b1;
			end
			if (is_query)    rd_idx_q <= '0;
			else if (iss_rd) rd_idx_q <= rd_idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (is_query) begin
			px_q <= coord_x[CW-1:0];
			py_q <= coord_y[CW-1:0];
		end
	end

	// Store access; index zero always opens the outer ring
	logic [EW-1:0] vtx_s1;

	always_ff @(posedge clk) begin
		if (wr_en)
			vtx_mem[cnt_q[IW-1:0]] <= {new_ring || (cnt_q == '0),
				coord_y[CW-1:0], coord_x[CW-1:0]};
		if (iss_rd)
			vtx_s1 <= vtx_mem[rd_idx_q[IW-1:0]];
	end

	// ------------------------------------------------------------------
	// s1: edge former. Normal edge (cur, prev); at a ring start or the
	// flush beat, the closing edge (first, prev) of the ring just ended.
	// ------------------------------------------------------------------
	logic tok_vld_s1, flush_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_vld_s1 <= 1'b0;
			flush_s1   <= 1'b0;
		end else begin
			tok_vld_s1 <= iss_rd || iss_flush;
			flush_s1   <= iss_flush;
		end
	end

	logic signed [CW-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic                 ring_open_q, outer_q;
	logic [RING_CNT_W-1:0] ring_n_q;

	logic signed [CW-1:0] cur_x, cur_y, ax, ay;
	logic cur_beg, closing, e_vld;

	assign cur_x   = vtx_s1[CW-1:0];
	assign cur_y   = vtx_s1[2*CW-1:CW];
	assign cur_beg = !flush_s1 && vtx_s1[2*CW];
	assign closing = flush_s1 || cur_beg;
	assign e_vld   = tok_vld_s1 && (!closing || ring_open_q);
	assign ax      = closing ? first_x_q : cur_x;
	assign ay      = closing ? first_y_q : cur_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_open_q <= 1'b0;
			outer_q     <= 1'b0;
			ring_n_q    <= '0;
		end else if (is_query) begin
			ring_open_q <= 1'b0;
			outer_q     <= 1'b0;
			ring_n_q    <= '0;
		end else if (tok_vld_s1 && cur_beg) begin
			ring_open_q <= 1'b1;
			outer_q     <= !ring_open_q;   // only the first ring is the boundary
			ring_n_q    <= RING_CNT_W'(1);
		end else if (tok_vld_s1 && !flush_s1 && ring_n_q != RING_CNT_W'(RING_MIN)) begin
			ring_n_q    <= ring_n_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_vld_s1 && !flush_s1) begin
			prev_x_q <= cur_x;
			prev_y_q <= cur_y;
			if (cur_beg) begin
				first_x_q <= cur_x;
				first_y_q <= cur_y;
			end
		end
	end

	// ------------------------------------------------------------------
	// s2: differences and straddle test
	// ------------------------------------------------------------------
	logic e_vld_s2, flush_s2;
	logic end_s2, big_s2, outer_s2, strad_s2, dypos_s2;
	logic signed [DW-1:0] dxp_s2, dy_s2, dxb_s2, dyp_s2;
	logic signed [DW-1:0] dy_w;

	assign dy_w = {prev_y_q[CW-1], prev_y_q} - {ay[CW-1], ay};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_vld_s2 <= 1'b0;
			flush_s2 <= 1'b0;
		end else begin
			e_vld_s2 <= e_vld;
			flush_s2 <= tok_vld_s1 && flush_s1;
		end
	end

	always_ff @(posedge clk) begin
		end_s2   <= closing;
		big_s2   <= (ring_n_q == RING_CNT_W'(RING_MIN));
		outer_s2 <= outer_q;
		strad_s2 <= (ay > py_q) != (prev_y_q > py_q);
		dypos_s2 <= (dy_w > 0);
		dy_s2    <= dy_w;
		dxp_s2   <= {px_q[CW-1], px_q} - {ax[CW-1], ax};
		dxb_s2   <= {prev_x_q[CW-1], prev_x_q} - {ax[CW-1], ax};
		dyp_s2   <= {py_q[CW-1], py_q} - {ay[CW-1], ay};
	end

	// ------------------------------------------------------------------
	// s3: the two cross products, one multiplier each
	// ------------------------------------------------------------------
	logic e_vld_s3;
	logic end_s3, big_s3, outer_s3, strad_s3, dypos_s3;
	logic signed [PW-1:0] lprod_s3, rprod_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_vld_s3 <= 1'b0;
			flush_s3 <= 1'b0;
		end else begin
			e_vld_s3 <= e_vld_s2;
			flush_s3 <= flush_s2;
		end
	end

	always_ff @(posedge clk) begin
		end_s3   <= end_s2;
		big_s3   <= big_s2;
		outer_s3 <= outer_s2;
		strad_s3 <= strad_s2;
		dypos_s3 <= dypos_s2;
		lprod_s3 <= PW'(dxp_s2) * PW'(dy_s2);
		rprod_s3 <= PW'(dxb_s2) * PW'(dyp_s2);
	end

	// Compare, crossing parity per ring, and the polygon verdict
	logic par_q, res_q;
	logic hit, ring_hit, par_d, res_d;

	assign hit      = strad_s3 && (dypos_s3 ? (lprod_s3 < rprod_s3) : (rprod_s3 < lprod_s3));
	assign ring_hit = (par_q ^ hit) && big_s3;

	always_comb begin
		par_d = par_q;
		res_d = res_q;
		if (e_vld_s3) begin
			if (end_s3) begin
				par_d = 1'b0;
				res_d = outer_s3 ? ring_hit : (res_q && !ring_hit);
			end else begin
				par_d = par_q ^ hit;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			par_q <= 1'b0;
			res_q <= 1'b0;
			done  <= 1'b0;
		end else begin
			done <= flush_s3;
			if (is_query) begin
				par_q <= 1'b0;
				res_q <= 1'b0;   // empty store answers outside
			end else begin
				par_q <= par_d;
				res_q <= res_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (flush_s3) begin
			inside_res <= res_d;
			overflowed <= ovf_q;
		end
	end

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	`PIP_ASSERT_NOW(a_flush_in_drain, flush_s3, state_q == ST_DRAIN, "flush beat outside drain")
	`PIP_ASSERT_NEXT(a_single_strobe, done, !done, "result strobe longer than one beat")
	`PIP_ASSERT_NEXT(a_query_busy, is_query, busy && !done, "query beat did not raise busy")
	`PIP_ASSERT_NOW(a_count_bound, 1'b1, cnt_q <= CNT_MAX, "vertex count beyond capacity")

endmodule

### dv/pip_holes_checker.sv
// Checker for point_in_polygon_with_holes_core: keeps its own copy of the vertex store,
// predicts each query answer when the command beat is taken and compares result beats.
// Depends on pip_holes_pkg only.
module pip_holes_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  mode,
	input  logic [31:0] coord_x,
	input  logic [31:0] coord_y,
	input  logic        new_ring,
	input  logic        done,
	input  logic        inside_res,
	input  logic        overflowed,
	output int          fail_count,
	output int          answers_due
);
	timeunit 1ns;
	timeprecision 1ps;

	import pip_holes_pkg::*;

	localparam int DEPTH = MAX_VERTICES_DEF;

	typedef struct packed {
		logic in_poly;
		logic overflowed;
	} answer_t;

	logic signed [31:0] vert_x [DEPTH];
	logic signed [31:0] vert_y [DEPTH];
	bit                 ring_head [DEPTH];
	int unsigned        stored;
	bit                 dropped;
	answer_t            answer_q [$];
	answer_t            due;

	// Even-odd crossing count over vertices first..stop-1, exact products, no division.
	function automatic bit ring_contains(int unsigned first, int unsigned stop,
			logic signed [31:0] px, logic signed [31:0] py);
		bit odd;
		int unsigned i, j;
		logic signed [33:0] qx, qy, ax, ay, bx, by, dy;
		logic signed [67:0] lhs, rhs;
		odd = 1'b0;
		if (stop - first < 3)
			return 1'b0;
		qx = px;
		qy = py;
		j = stop - 1;
		for (i = first; i < stop; i++) begin
			ax = vert_x[i];
			ay = vert_y[i];
			bx = vert_x[j];
			by = vert_y[j];
			// flat edges never straddle, so they drop out here
			if ((ay > qy) != (by > qy)) begin
				dy  = by - ay;
				lhs = (qx - ax) * dy;
				rhs = (bx - ax) * (qy - ay);
				if (dy > 0 ? lhs < rhs : rhs < lhs)
					odd = !odd;
			end
			j = i;
		end
		return odd;
	endfunction

	// Inside the outer ring and in no hole; an empty store answers outside.
	function automatic bit polygon_contains(logic signed [31:0] px, logic signed [31:0] py);
		int unsigned head, tail, rings;
		bit hit;
		head  = 0;
		rings = 0;
		while (head < stored) begin
			tail = head + 1;
			while (tail < stored && !ring_head[tail])
				tail++;
			hit = ring_contains(head, tail, px, py);
			if (rings == 0 && !hit)
				return 1'b0;
			if (rings != 0 && hit)
				return 1'b0;
			rings++;
			head = tail;
		end
		return rings != 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored  = 0;
			dropped = 1'b0;
			answer_q.delete();
		end else begin
			// result first: a command beat on the same edge belongs after it
			if (done) begin
				if (answer_q.size() == 0) begin
					$display("%0t: result beat with no query outstanding (inside_res %b, overflowed %b)",
						$time, inside_res, overflowed);
					fail_count++;
				end else begin
					due = answer_q.pop_front();
					if (inside_res !== due.in_poly) begin
						$display("%0t: inside_res expected %b, actual %b",
							$time, due.in_poly, inside_res);
						fail_count++;
					end
					if (overflowed !== due.overflowed) begin
						$display("%0t: overflowed expected %b, actual %b",
							$time, due.overflowed, overflowed);
						fail_count++;
					end
				end
			end
			if (start && !busy) begin
				case (mode)
					MODE_CLEAR: begin
						stored  = 0;
						dropped = 1'b0;
					end
					MODE_LOAD: begin
						if (stored >= DEPTH) begin
							dropped = 1'b1;
						end else begin
							vert_x[stored]    = coord_x;
							vert_y[stored]    = coord_y;
							ring_head[stored] = new_ring || stored == 0;
							stored++;
						end
					end
					MODE_QUERY: begin
						due.in_poly    = polygon_contains(coord_x, coord_y);
						due.overflowed = dropped;
						answer_q.push_back(due);
					end
					default: ;
				endcase
			end
			answers_due = answer_q.size();
		end
	end

endmodule

### dv/tb_top.sv
// Top of the testbench for point_in_polygon_with_holes_core: clock, reset and command stimulus.
// Depends on pip_holes_pkg, the core itself and pip_holes_checker, which predicts and compares.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pip_holes_pkg::*;

	localparam logic [1:0] MODE_SPARE = 2'd3;    // unused code, the core ignores it
	localparam int PHASE_BEATS    = 633;         // counted command beats per idling phase
	localparam int SETTLE_CYCLES  = 80;          // > longest query, on a full store of 64 vertices
	localparam int WATCHDOG_LIMIT = 2000;        // quiet cycles before giving up
	localparam int Q1             = 1 << 16;     // 1.0 in Q16.16

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        start    = 1'b0;
	logic [1:0]  mode     = MODE_CLEAR;
	logic [31:0] coord_x  = '0;
	logic [31:0] coord_y  = '0;
	logic        new_ring = 1'b0;
	logic        busy, done, inside_res, overflowed;

	int fail_count;
	int answers_due;
	int idle_pct;       // chance in a hundred that the sender holds back a cycle
	int beats_sent;     // command beats taken, the ignored code left out
	int quiet_cycles;

	// vertices of the current polygon, reused as query points to land on the boundary
	logic [31:0] probe_xs [$];
	logic [31:0] probe_ys [$];
	// one ring being assembled before it is loaded
	logic [31:0] ring_xs [$];
	logic [31:0] ring_ys [$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	point_in_polygon_with_holes_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.new_ring   (new_ring),
		.done       (done),
		.inside_res (inside_res),
		.overflowed (overflowed)
	);

	pip_holes_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.mode        (mode),
		.coord_x     (coord_x),
		.coord_y     (coord_y),
		.new_ring    (new_ring),
		.done        (done),
		.inside_res  (inside_res),
		.overflowed  (overflowed),
		.fail_count  (fail_count),
		.answers_due (answers_due)
	);

	// Watchdog: any command or result beat counts as progress.
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// One command beat. Entered just after a falling edge, returns just after one.
	// Idle cycles drop start and scramble mode and coordinates, so they are never trusted while start is low.
	task automatic send_cmd(input logic [1:0] m, input logic [31:0] x, input logic [31:0] y,
			input logic nr);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start   <= 1'b0;
			mode    <= 2'($urandom_range(3));
			coord_x <= $urandom();
			coord_y <= $urandom();
			@(negedge clk);
		end
		start    <= 1'b1;
		mode     <= m;
		coord_x  <= x;
		coord_y  <= y;
		new_ring <= nr;
		if (m != MODE_SPARE)
			beats_sent++;
		// busy is sampled before the core updates it on this edge
		do begin
			@(posedge clk);
		end while (busy);
		@(negedge clk);
	endtask

	// Hold off until every query answer has come back; always waits on the clock before
	// it returns, so start is never dropped and raised in the same step.
	task automatic pause_until_answered();
		start <= 1'b0;
		do begin
			@(negedge clk);
		end while (answers_due != 0);
	endtask

	function automatic int pick_unit();
		case ($urandom_range(3))
			0:       return 1;
			1:       return 1 << 8;
			2:       return Q1;
			default: return 1 << 24;    // +-120 grid steps still fit in 32 bits
		endcase
	endfunction

	// Grid point times unit (Q16.16 when unit is Q1); rough adds fraction bits so edges are no longer flat.
	function automatic logic [31:0] grid_coord(int g, int unit, bit rough);
		int frac;
		frac = rough ? int'($urandom_range(unit - 1)) : 0;
		return 32'(g * unit + frac);
	endfunction

	function automatic int rand_grid();
		return int'($urandom_range(240)) - 120;
	endfunction

	task automatic add_vertex(int gx, int gy, int unit, bit rough);
		ring_xs.push_back(grid_coord(gx, unit, rough));
		ring_ys.push_back(grid_coord(gy, unit, rough));
	endtask

	task automatic start_polygon();
		send_cmd(MODE_CLEAR, $urandom(), $urandom(), 1'($urandom_range(1)));
		probe_xs.delete();
		probe_ys.delete();
	endtask

	// Loads the assembled ring in either winding; head is new_ring of its first vertex.
	task automatic load_ring(bit reverse, bit head);
		int n, idx;
		n = ring_xs.size();
		for (int k = 0; k < n; k++) begin
			idx = reverse ? n - 1 - k : k;
			send_cmd(MODE_LOAD, ring_xs[idx], ring_ys[idx], k == 0 ? head : 1'b0);
			probe_xs.push_back(ring_xs[idx]);
			probe_ys.push_back(ring_ys[idx]);
		end
		ring_xs.delete();
		ring_ys.delete();
	endtask

	// A handful of queries: free points, exact vertices, and points on a vertex row
	// or column, which is where flat edges and crossing ties show up.
	task automatic probe_polygon(int unit, bit rough);
		int n, pick, k;
		logic [31:0] qx, qy;
		n = $urandom_range(12, 3);
		repeat (n) begin
			pick = probe_xs.size() == 0 ? 0 : int'($urandom_range(5));
			k    = probe_xs.size() == 0 ? 0 : int'($urandom_range(probe_xs.size() - 1));
			qx   = grid_coord(rand_grid(), unit, rough);
			qy   = grid_coord(rand_grid(), unit, rough);
			case (pick)
				1: begin
					qx = probe_xs[k];
					qy = probe_ys[k];
				end
				2: qy = probe_ys[k];
				3: qx = probe_xs[k];
				4: begin
					qx = $urandom();
					qy = $urandom();
				end
				default: ;
			endcase
			send_cmd(MODE_QUERY, qx, qy, 1'($urandom_range(1)));
		end
	endtask

	// Rectangle outline, maybe with a dent in the bottom edge, and up to three holes.
	// Now and then the clear is skipped so the rings pile onto the previous polygon.
	task automatic shape_with_holes();
		int unit, x0, x1, y0, y1, cx, cy, h, corners;
		bit rough;
		unit  = pick_unit();
		rough = 1'($urandom_range(1));
		x0 = -int'($urandom_range(100, 40));
		x1 = int'($urandom_range(100, 40));
		y0 = -int'($urandom_range(100, 40));
		y1 = int'($urandom_range(100, 40));
		if ($urandom_range(7) != 0)
			start_polygon();
		add_vertex(x0, y0, unit, rough);
		if ($urandom_range(1))
			add_vertex((x0 + x1) / 2, y0 + int'($urandom_range(y1 - y0)), unit, rough);
		add_vertex(x1, y0, unit, rough);
		add_vertex(x1, y1, unit, rough);
		add_vertex(x0, y1, unit, rough);
		load_ring(1'($urandom_range(1)), 1'($urandom_range(1)));
		repeat ($urandom_range(3)) begin
			cx = x0 + int'($urandom_range(x1 - x0));
			cy = y0 + int'($urandom_range(y1 - y0));
			h  = $urandom_range(15, 1);
			// one hole in eight is too short to enclose anything
			corners = $urandom_range(7) == 0 ? $urandom_range(2, 1) : $urandom_range(4, 3);
			add_vertex(cx - h, cy - h, unit, rough);
			if (corners > 1)
				add_vertex(cx + h, cy - h, unit, rough);
			if (corners > 2)
				add_vertex(cx + h, cy + h, unit, rough);
			if (corners > 3)
				add_vertex(cx - h, cy + h, unit, rough);
			load_ring(1'($urandom_range(1)), 1'b1);
		end
		probe_polygon(unit, rough);
	endtask

	// Scattered vertices, self-crossing rings and short rings; a quarter span the whole
	// 32-bit range so the edge products reach their full width.
	task automatic scatter_polygon();
		int unit, rings, verts;
		bit wide, rough;
		unit  = pick_unit();
		wide  = $urandom_range(3) == 0;
		rough = 1'($urandom_range(1));
		if ($urandom_range(7) != 0)
			start_polygon();
		rings = $urandom_range(4, 1);
		for (int r = 0; r < rings; r++) begin
			verts = $urandom_range(8, 1);
			repeat (verts) begin
				if (wide) begin
					ring_xs.push_back($urandom());
					ring_ys.push_back($urandom());
				end else begin
					add_vertex(rand_grid(), rand_grid(), unit, rough);
				end
			end
			load_ring(1'($urandom_range(1)), r == 0 ? 1'($urandom_range(1)) : 1'b1);
		end
		probe_polygon(unit, rough);
	endtask

	// Fills the store to the brim and sometimes past it; queries then carry the sticky flag.
	task automatic overflow_fill();
		int total;
		logic [31:0] vx, vy;
		start_polygon();
		total = MAX_VERTICES_DEF + int'($urandom_range(6));
		for (int k = 0; k < total; k++) begin
			vx = grid_coord(rand_grid(), Q1, 1'b1);
			vy = grid_coord(rand_grid(), Q1, 1'b1);
			send_cmd(MODE_LOAD, vx, vy, k != 0 && $urandom_range(7) == 0);
			probe_xs.push_back(vx);
			probe_ys.push_back(vy);
		end
		probe_polygon(Q1, 1'b1);
	endtask

	// Anything at all, the unused code among it.
	task automatic noise_burst();
		repeat ($urandom_range(6, 1))
			send_cmd(2'($urandom_range(3)), $urandom(), $urandom(), 1'($urandom_range(1)));
	endtask

	initial begin
		int target;
		idle_pct = 0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// --- directed part ---
		// empty store answers outside
		send_cmd(MODE_QUERY, '0, '0, 1'b0);
		send_cmd(MODE_SPARE, '1, '1, 1'b1);
		// full-range square; first vertex opens the outer ring with new_ring low
		send_cmd(MODE_LOAD, 32'h8000_0000, 32'h8000_0000, 1'b0);
		send_cmd(MODE_LOAD, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
		send_cmd(MODE_LOAD, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
		send_cmd(MODE_LOAD, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
		send_cmd(MODE_QUERY, '0, '0, 1'b0);
		send_cmd(MODE_QUERY, 32'h8000_0000, 32'h8000_0000, 1'b1);
		send_cmd(MODE_QUERY, 32'h7fff_ffff, '0, 1'b0);
		// on the bottom row: flat edge must not count
		send_cmd(MODE_QUERY, '0, 32'h8000_0000, 1'b0);
		// triangular hole round the origin
		send_cmd(MODE_LOAD, 32'(-100 * Q1), 32'(-100 * Q1), 1'b1);
		send_cmd(MODE_LOAD, 32'(100 * Q1), 32'(-100 * Q1), 1'b0);
		send_cmd(MODE_LOAD, '0, 32'(100 * Q1), 1'b0);
		send_cmd(MODE_QUERY, '0, '0, 1'b0);
		send_cmd(MODE_QUERY, 32'h4000_0000, 32'h4000_0000, 1'b0);
		// two-vertex ring as a hole: encloses nothing
		send_cmd(MODE_LOAD, 32'hc000_0000, 32'h4000_0000, 1'b1);
		send_cmd(MODE_LOAD, 32'h4000_0005, 32'h4000_0005, 1'b0);
		send_cmd(MODE_QUERY, 32'h4000_0000, 32'h4000_0000, 1'b0);
		// level with the hole's flat bottom edge
		send_cmd(MODE_QUERY, 32'(50 * Q1), 32'(-100 * Q1), 1'b0);
		send_cmd(MODE_CLEAR, '1, '1, 1'b1);
		send_cmd(MODE_QUERY, '0, '0, 1'b0);
		// outer ring of a single vertex
		send_cmd(MODE_LOAD, 32'(Q1), 32'(Q1), 1'b1);
		send_cmd(MODE_QUERY, 32'(Q1), 32'(Q1), 1'b0);
		pause_until_answered();

		// --- random part: a full store first, then three idling phases ---
		overflow_fill();
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0:       idle_pct = 35;
				1:       idle_pct = 69;
				default: idle_pct = 0;
			endcase
			target = beats_sent + PHASE_BEATS;
			while (beats_sent < target) begin
				case ($urandom_range(19))
					0, 1, 2, 3, 4, 5, 6, 7, 8: shape_with_holes();
					9, 10, 11, 12, 13, 14, 15: scatter_polygon();
					16:                        overflow_fill();
					default:                   noise_burst();
				endcase
				if ($urandom_range(11) == 0)
					pause_until_answered();
			end
			pause_until_answered();
		end

		// pause_until_answered has already drained the answers and dropped start
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### sim.f
+incdir+rtl
rtl/pip_holes_pkg.sv
rtl/point_in_polygon_with_holes_core.sv
dv/pip_holes_checker.sv
dv/tb_top.sv
